FILE: rtl/stc_pkg.sv
// Shared types, constants and helper functions of the source character tokenizer.
`default_nettype none

package stc_pkg;

  localparam int POS_BITS  = 24;
  localparam int LINE_BITS = 16;
  localparam int RUN_MAX   = 3;   // most tokens that one byte can produce
  localparam int RQ_DEPTH  = 4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_SYMBOL  = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  localparam logic KW_ID_FN  = 1'b0;
  localparam logic KW_ID_VAR = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_STR
  } scan_mode_t;

  typedef enum logic [2:0] {
    KW_EMPTY,
    KW_F,
    KW_FN,
    KW_V,
    KW_VA,
    KW_VAR,
    KW_NONE
  } kw_state_t;

  typedef struct packed {
    scan_mode_t           mode;
    kw_state_t            kw;
    logic [LINE_BITS-1:0] cur_line;
    logic [POS_BITS-1:0]  cur_col;
    logic [POS_BITS-1:0]  offset;
    logic [LINE_BITS-1:0] nl_count;
    logic [LINE_BITS-1:0] tok_line;
    logic [POS_BITS-1:0]  tok_col;
    logic [POS_BITS-1:0]  tok_off;
  } scan_state_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic                 keyword_id;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  start_col;
    logic [POS_BITS-1:0]  end_col;
    logic [POS_BITS-1:0]  start_off;
    logic [7:0]           symbol_char;
  } token_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } rq_entry_t;

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
    return (&v) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic kw_state_t kw_next(input kw_state_t k, input logic [7:0] c);
    kw_state_t r;
    r = KW_NONE;
    unique case (k)
      KW_EMPTY: begin
        if (c == "f") r = KW_F;
        else if (c == "v") r = KW_V;
      end
      KW_F:  if (c == "n") r = KW_FN;
      KW_V:  if (c == "a") r = KW_VA;
      KW_VA: if (c == "r") r = KW_VAR;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

  function automatic scan_state_t scan_start(input logic [LINE_BITS-1:0] first_line);
    scan_state_t s;
    s          = '0;
    s.mode     = MODE_IDLE;
    s.kw       = KW_EMPTY;
    s.cur_line = first_line;
    s.cur_col  = POS_BITS'(1);
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/stc_if.sv
// Handshake channel interfaces for source bytes and token results.
`default_nettype none

interface stc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       is_last;

  modport source(output valid, source_char, is_last, input ready);
  modport sink(input valid, source_char, is_last, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           token_kind;
  logic                 keyword_id;
  logic [LINE_BITS-1:0] token_line;
  logic [POS_BITS-1:0]  start_column;
  logic [POS_BITS-1:0]  end_column;
  logic [POS_BITS-1:0]  start_offset;
  logic [7:0]           symbol_char;
  logic                 last_of_run;

  modport source(output valid, token_kind, keyword_id, token_line, start_column, end_column,
                 start_offset, symbol_char, last_of_run, input ready);
  modport sink(input valid, token_kind, keyword_id, token_line, start_column, end_column,
               start_offset, symbol_char, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/stc_core.sv
// Scanner state, first-line register and per-byte token decision logic.
`default_nettype none

module stc_core import stc_pkg::*; (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        take,
  input  wire  [7:0]                 char_in,
  input  wire                        last_in,
  input  wire                        cfg_we,
  input  wire  [LINE_BITS-1:0]       cfg_wdata,
  output token_t [RUN_MAX-1:0]       recs,
  output logic [1:0]                 rec_n
);

  scan_state_t          st_r, st_nxt;
  logic [LINE_BITS-1:0] first_line_r;
  scan_state_t          s;
  token_t [RUN_MAX-1:0] recs_c;
  logic [1:0]           n;
  logic                 taken;

  function automatic token_t pending_tok(input scan_state_t ps, input logic [POS_BITS-1:0] ec);
    token_t t;
    t            = '0;
    t.kind       = KIND_STRING;
    t.keyword_id = KW_ID_FN;
    if (ps.mode == MODE_IDENT) begin
      t.kind = KIND_IDENT;
      if (ps.kw == KW_FN) begin
        t.kind = KIND_KEYWORD;
      end else if (ps.kw == KW_VAR) begin
        t.kind       = KIND_KEYWORD;
        t.keyword_id = KW_ID_VAR;
      end
    end else if (ps.mode == MODE_NUM) begin
      t.kind = KIND_INT;
    end
    t.line      = ps.tok_line;
    t.start_col = ps.tok_col;
    t.end_col   = ec;
    t.start_off = ps.tok_off;
    return t;
  endfunction

  always_comb begin
    s      = st_r;
    n      = 2'd0;
    taken  = 1'b0;
    recs_c = '0;

    // A running identifier or number ends at the first byte that does not
    // continue it; that byte is then scanned as if the scanner were idle.
    case (s.mode)
      MODE_IDENT: begin
        if (is_alpha(char_in)) begin
          s.kw  = kw_next(s.kw, char_in);
          taken = 1'b1;
        end else begin
          recs_c[n] = pending_tok(s, s.cur_col);
          n         = n + 2'd1;
          s.mode    = MODE_IDLE;
          s.kw      = KW_EMPTY;
        end
      end
      MODE_NUM: begin
        if (is_digit(char_in)) begin
          taken = 1'b1;
        end else begin
          recs_c[n] = pending_tok(s, s.cur_col);
          n         = n + 2'd1;
          s.mode    = MODE_IDLE;
          s.kw      = KW_EMPTY;
        end
      end
      MODE_STR: begin
        taken = 1'b1;
        if (char_in == CH_QUOTE) begin
          recs_c[n] = pending_tok(s, pos_inc(s.cur_col));
          n         = n + 2'd1;
          s.mode    = MODE_IDLE;
          s.kw      = KW_EMPTY;
        end
      end
      default: ;
    endcase

    if (!taken) begin
      if (is_digit(char_in) || is_alpha(char_in) || char_in == CH_QUOTE) begin
        s.mode     = is_digit(char_in) ? MODE_NUM : (is_alpha(char_in) ? MODE_IDENT : MODE_STR);
        s.kw       = is_alpha(char_in) ? kw_next(KW_EMPTY, char_in) : KW_EMPTY;
        s.tok_line = s.cur_line;
        s.tok_col  = s.cur_col;
        s.tok_off  = s.offset;
      end else if (is_punct(char_in)) begin
        recs_c[n].kind        = KIND_SYMBOL;
        recs_c[n].keyword_id  = KW_ID_FN;
        recs_c[n].line        = s.cur_line;
        recs_c[n].start_col   = s.cur_col;
        recs_c[n].end_col     = pos_inc(s.cur_col);
        recs_c[n].start_off   = s.offset;
        recs_c[n].symbol_char = char_in;
        n                     = n + 2'd1;
      end
    end

    s.offset = pos_inc(s.offset);
    if (char_in == CH_LF) begin
      s.cur_line = line_inc(s.cur_line);
      s.nl_count = line_inc(s.nl_count);
      s.cur_col  = POS_BITS'(1);
    end else begin
      s.cur_col = pos_inc(s.cur_col);
    end

    if (last_in) begin
      if (s.mode != MODE_IDLE) begin
        recs_c[n] = pending_tok(s, s.cur_col);
        n         = n + 2'd1;
      end
      recs_c[n].kind        = KIND_END;
      recs_c[n].keyword_id  = KW_ID_FN;
      recs_c[n].line        = s.nl_count;
      recs_c[n].start_col   = s.offset;
      recs_c[n].end_col     = pos_inc(s.offset);
      recs_c[n].start_off   = s.offset;
      recs_c[n].symbol_char = 8'd0;
      n                     = n + 2'd1;
      s                     = scan_start(first_line_r);
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (take) begin
      st_nxt = s;
    end else if (cfg_we && st_r.offset == '0 && st_r.mode == MODE_IDLE) begin
      // A new first line takes effect at once while no byte has been scanned.
      st_nxt.cur_line = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= scan_start(LINE_BITS'(1));
      first_line_r <= LINE_BITS'(1);
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        first_line_r <= cfg_wdata;
      end
    end
  end

  assign recs  = recs_c;
  assign rec_n = take ? n : 2'd0;

endmodule

`default_nettype wire

FILE: rtl/stc_rq.sv
// Small result queue that takes up to three tokens per cycle and releases one.
`default_nettype none

module stc_rq import stc_pkg::*; (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [1:0]            push_n,
  input  token_t [RUN_MAX-1:0]  recs,
  input  wire                   pop,
  output rq_entry_t             head,
  output logic                  not_empty,
  output logic                  room
);

  localparam int PTR_BITS = $clog2(RQ_DEPTH);
  localparam int CNT_BITS = $clog2(RQ_DEPTH + 1);

  rq_entry_t             mem [RQ_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0]   cnt_after_pop;

  assign cnt_after_pop = cnt_r - CNT_BITS'(pop);
  assign cnt_nxt       = cnt_after_pop + CNT_BITS'(push_n);
  // Room means a byte that produces the largest run still fits.
  assign room          = cnt_after_pop <= CNT_BITS'(RQ_DEPTH - RUN_MAX);
  assign not_empty     = cnt_r != '0;
  assign head          = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < RUN_MAX; i++) begin
      if (2'(i) < push_n) begin
        mem[wr_ptr_r + PTR_BITS'(i)] <= '{tok: recs[i], last: (2'(i) == push_n - 2'd1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_BITS'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_BITS'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/source_char_tokenizer_unit.sv
// Top level of the source character tokenizer: input register, scanner core and result queue.
`default_nettype none

// Takes one source byte per cycle and emits token descriptors (keyword, identifier, integer,
// string, symbol, and an end token after the byte marked is_last). An accepted byte is held in
// the input register until the queue has room, is scanned there, and its tokens enter a
// four-entry result queue whose head is offered on out_chan. The input keeps taking a byte
// every cycle as long as the queue, after this cycle's transfer, holds at most one token; a
// byte that produces two or three tokens, or a stalled output, holds the input until the queue
// has drained that far again. cfg_wdata sets the line number of the first source line and may
// be written only while no byte is in flight.
module source_char_tokenizer_unit import stc_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  stc_in_if.sink               in_chan,
  stc_out_if.source            out_chan,
  input  wire                  cfg_we,
  input  wire  [LINE_BITS-1:0] cfg_wdata
);

  logic                 hold_v_r;
  logic [7:0]           hold_char_r;
  logic                 hold_last_r;
  logic                 take;
  logic                 room;
  logic                 q_not_empty;
  logic                 pop;
  token_t [RUN_MAX-1:0] recs;
  logic [1:0]           rec_n;
  rq_entry_t            head;

  assign take          = hold_v_r && room;
  assign in_chan.ready = !hold_v_r || take;
  assign pop           = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      hold_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      hold_char_r <= in_chan.source_char;
      hold_last_r <= in_chan.is_last;
    end
  end

  stc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_in   (hold_char_r),
    .last_in   (hold_last_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .recs      (recs),
    .rec_n     (rec_n)
  );

  stc_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (rec_n),
    .recs      (recs),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .room      (room)
  );

  assign out_chan.valid        = q_not_empty;
  assign out_chan.token_kind   = head.tok.kind;
  assign out_chan.keyword_id   = head.tok.keyword_id;
  assign out_chan.token_line   = head.tok.line;
  assign out_chan.start_column = head.tok.start_col;
  assign out_chan.end_column   = head.tok.end_col;
  assign out_chan.start_offset = head.tok.start_off;
  assign out_chan.symbol_char  = head.tok.symbol_char;
  assign out_chan.last_of_run  = head.last;

endmodule

`default_nettype wire

FILE: rtl/stc_checker.sv
// Port-level checks of the tokenizer results, bound to the top level.
`default_nettype none

module stc_checker import stc_pkg::*; (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [2:0]           token_kind,
  input wire                 keyword_id,
  input wire [POS_BITS-1:0]  start_column,
  input wire [POS_BITS-1:0]  end_column,
  input wire [7:0]           symbol_char,
  input wire                 last_of_run
);

  // A stalled token stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(start_column)
      && $stable(end_column) && $stable(last_of_run))
    else $error("stalled result changed");

  // The end token is always the final transfer caused by its byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind == KIND_END |-> last_of_run)
    else $error("end token not marked last of run");

  // Only keywords carry a keyword id.
  a_kw_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && keyword_id |-> token_kind == KIND_KEYWORD)
    else $error("keyword id on a non-keyword token");

  // Symbols carry a nonzero byte, other kinds carry zero.
  a_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((token_kind == KIND_SYMBOL) == (symbol_char != 8'd0)))
    else $error("symbol byte does not match token kind");

endmodule

bind source_char_tokenizer_unit stc_checker u_stc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .token_kind   (out_chan.token_kind),
  .keyword_id   (out_chan.keyword_id),
  .start_column (out_chan.start_column),
  .end_column   (out_chan.end_column),
  .symbol_char  (out_chan.symbol_char),
  .last_of_run  (out_chan.last_of_run)
);

`default_nettype wire

FILE: tb/tb_source_char_tokenizer_unit.sv
// Self-checking testbench of the source character tokenizer: directed and random sources.
`default_nettype none

module tb_source_char_tokenizer_unit;
  import stc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BYTES  = 155;
  localparam int NEWLINE_FLOOD = 20;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [LINE_BITS-1:0] cfg_wdata;

  stc_in_if  in_chan();
  stc_out_if out_chan();

  source_char_tokenizer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scanner state as the testbench expects it.
  logic [LINE_BITS-1:0] first_line_reg;
  scan_mode_t           scan_mode;
  kw_state_t            kw_prog;
  logic [LINE_BITS-1:0] line_now;
  logic [POS_BITS-1:0]  col_now;
  logic [POS_BITS-1:0]  offs_now;
  logic [LINE_BITS-1:0] nl_seen;
  logic [LINE_BITS-1:0] tok_line;
  logic [POS_BITS-1:0]  tok_col;
  logic [POS_BITS-1:0]  tok_off;

  rq_entry_t   expected_tokens[$];
  rq_entry_t   run_tokens[$];
  logic [7:0]  src_bytes[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          in_gaps;
  bit          out_stalls;
  string       near_words[6] = '{"f", "v", "va", "fnx", "vars", "vAr"};

  function automatic logic is_letter(logic [7:0] c);
    return c inside {["A":"Z"], ["a":"z"]};
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  // Punctuation is every printable non-space byte that is neither a letter nor a digit.
  function automatic logic is_mark(logic [7:0] c);
    return c inside {[8'd33:8'd126]} && !is_letter(c) && !is_numeral(c);
  endfunction

  function automatic logic [POS_BITS-1:0] sat_pos(logic [POS_BITS-1:0] v);
    return (&v) ? v : POS_BITS'(v + 1);
  endfunction

  function automatic logic [LINE_BITS-1:0] sat_line(logic [LINE_BITS-1:0] v);
    return (&v) ? v : LINE_BITS'(v + 1);
  endfunction

  function automatic kw_state_t kw_step(kw_state_t k, logic [7:0] c);
    case (k)
      KW_EMPTY: return (c == "f") ? KW_F : ((c == "v") ? KW_V : KW_NONE);
      KW_F:     return (c == "n") ? KW_FN : KW_NONE;
      KW_V:     return (c == "a") ? KW_VA : KW_NONE;
      KW_VA:    return (c == "r") ? KW_VAR : KW_NONE;
      default:  return KW_NONE;
    endcase
  endfunction

  function automatic void restart_scan();
    scan_mode = MODE_IDLE;
    kw_prog   = KW_EMPTY;
    line_now  = first_line_reg;
    col_now   = POS_BITS'(1);
    offs_now  = '0;
    nl_seen   = '0;
    tok_line  = '0;
    tok_col   = '0;
    tok_off   = '0;
  endfunction

  function automatic void apply_first_line(logic [LINE_BITS-1:0] v);
    first_line_reg = v;
    // The new value only reaches the current source if no byte of it was taken yet.
    if (offs_now == '0 && scan_mode == MODE_IDLE) line_now = v;
  endfunction

  function automatic void add_token(logic [2:0] kind, logic kw_id, logic [LINE_BITS-1:0] line,
                                    logic [POS_BITS-1:0] scol, logic [POS_BITS-1:0] ecol,
                                    logic [POS_BITS-1:0] soff, logic [7:0] sym);
    rq_entry_t e;
    e.tok.kind        = kind;
    e.tok.keyword_id  = kw_id;
    e.tok.line        = line;
    e.tok.start_col   = scol;
    e.tok.end_col     = ecol;
    e.tok.start_off   = soff;
    e.tok.symbol_char = sym;
    e.last            = 1'b0;
    run_tokens = {run_tokens, e};
  endfunction

  function automatic void close_token(logic [POS_BITS-1:0] ecol);
    logic [2:0] kind;
    logic       kw_id;
    kind  = KIND_STRING;
    kw_id = KW_ID_FN;
    if (scan_mode == MODE_IDENT) begin
      kind = KIND_IDENT;
      if (kw_prog == KW_FN) begin
        kind = KIND_KEYWORD;
      end else if (kw_prog == KW_VAR) begin
        kind  = KIND_KEYWORD;
        kw_id = KW_ID_VAR;
      end
    end else if (scan_mode == MODE_NUM) begin
      kind = KIND_INT;
    end
    add_token(kind, kw_id, tok_line, tok_col, ecol, tok_off, 8'h00);
    scan_mode = MODE_IDLE;
    kw_prog   = KW_EMPTY;
  endfunction

  function automatic void open_token(scan_mode_t m);
    scan_mode = m;
    kw_prog   = KW_EMPTY;
    tok_line  = line_now;
    tok_col   = col_now;
    tok_off   = offs_now;
  endfunction

  // Works out the tokens that one accepted byte releases and queues them for the checker.
  function automatic void predict_byte(logic [7:0] c, logic last);
    logic taken;
    taken = 1'b0;
    run_tokens.delete();
    case (scan_mode)
      MODE_IDENT: begin
        if (is_letter(c)) begin
          kw_prog = kw_step(kw_prog, c);
          taken   = 1'b1;
        end else begin
          close_token(col_now);
        end
      end
      MODE_NUM: begin
        if (is_numeral(c)) taken = 1'b1;
        else close_token(col_now);
      end
      MODE_STR: begin
        taken = 1'b1;
        if (c == CH_QUOTE) close_token(sat_pos(col_now));
      end
      default: ;
    endcase

    // A byte that ended an identifier or number is scanned again as if the scanner were idle.
    if (!taken) begin
      if (is_numeral(c)) begin
        open_token(MODE_NUM);
      end else if (is_letter(c)) begin
        open_token(MODE_IDENT);
        kw_prog = kw_step(KW_EMPTY, c);
      end else if (c == CH_QUOTE) begin
        open_token(MODE_STR);
      end else if (is_mark(c)) begin
        add_token(KIND_SYMBOL, KW_ID_FN, line_now, col_now, sat_pos(col_now), offs_now, c);
      end
    end

    offs_now = sat_pos(offs_now);
    if (c == CH_LF) begin
      line_now = sat_line(line_now);
      nl_seen  = sat_line(nl_seen);
      col_now  = POS_BITS'(1);
    end else begin
      col_now = sat_pos(col_now);
    end

    if (last) begin
      if (scan_mode != MODE_IDLE) close_token(col_now);
      add_token(KIND_END, KW_ID_FN, nl_seen, offs_now, sat_pos(offs_now), offs_now, 8'h00);
      restart_scan();
    end

    if (run_tokens.size() > 0) begin
      run_tokens[$].last = 1'b1;
      expected_tokens = {expected_tokens, run_tokens};
    end
  endfunction

  // ---------------------------------------------------------------- result checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rq_entry_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $error("token_kind: expected no token, actual 0x%0h at offset 0x%0h",
               out_chan.token_kind, out_chan.start_offset);
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", 32'(want.tok.kind), 32'(out_chan.token_kind));
        check_field("keyword_id", 32'(want.tok.keyword_id), 32'(out_chan.keyword_id));
        check_field("token_line", 32'(want.tok.line), 32'(out_chan.token_line));
        check_field("start_column", 32'(want.tok.start_col), 32'(out_chan.start_column));
        check_field("end_column", 32'(want.tok.end_col), 32'(out_chan.end_column));
        check_field("start_offset", 32'(want.tok.start_off), 32'(out_chan.start_offset));
        check_field("symbol_char", 32'(want.tok.symbol_char), 32'(out_chan.symbol_char));
        check_field("last_of_run", 32'(want.last), 32'(out_chan.last_of_run));
      end
    end
  end

  // Token receiver: when out_stalls is set, holds ready low for a random stall before each transfer.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_stalls ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("source_char_tokenizer_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic send_byte(logic [7:0] c, logic last);
    int gap;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.source_char <= c;
    in_chan.is_last     <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_byte(c, last);
  endtask

  task automatic send_source();
    foreach (src_bytes[i]) send_byte(src_bytes[i], i == src_bytes.size() - 1);
  endtask

  // Bytes that release no token may still be in the pipeline when the queue runs empty.
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_line(logic [LINE_BITS-1:0] v);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    apply_first_line(v);
    cfg_we <= 1'b0;
  endtask

  function automatic void append_byte(logic [7:0] c);
    src_bytes = {src_bytes, c};
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] random_space();
    logic [7:0] spaces[6];
    spaces = '{8'h09, CH_LF, 8'h0B, 8'h0C, 8'h0D, 8'h20};
    return spaces[$urandom_range(0, 5)];
  endfunction

  function automatic void append_fragment();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: append_text($urandom_range(0, 1) ? "fn" : "var");
      1: append_text(near_words[$urandom_range(0, 5)]);
      2: repeat ($urandom_range(1, 5)) append_byte(random_letter());
      3: repeat ($urandom_range(1, 4)) append_byte(8'("0" + $urandom_range(0, 9)));
      4: begin
        append_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE || $urandom_range(0, 3) == 0) c = CH_LF;
          append_byte(c);
        end
        // Now and then the string stays open and swallows the rest of the source.
        if ($urandom_range(0, 9) != 0) append_byte(CH_QUOTE);
      end
      5: begin
        do c = 8'($urandom_range(33, 126));
        while (!is_mark(c) || c == CH_QUOTE);
        append_byte(c);
      end
      6: append_byte(random_space());
      default: begin
        case ($urandom_range(0, 2))
          0:       c = 8'($urandom_range(0, 8));
          1:       c = 8'($urandom_range(14, 31));
          default: c = 8'($urandom_range(127, 255));
        endcase
        append_byte(c);
      end
    endcase
  endfunction

  function automatic logic [LINE_BITS-1:0] pick_first_line();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return LINE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_sources();
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    // Both keywords, an identifier cut short by a digit, a string across a newline, symbols,
    // skipped control and high bytes, and a final ';' that releases three tokens at once.
    src_bytes.delete();
    append_text("fn var\nx9\"a\n\"!");
    append_byte(8'h80);
    append_byte(8'hFF);
    append_byte(8'h00);
    append_text("\t~ab;");
    send_source();
    // A lone quote as the final byte is an unterminated string.
    src_bytes.delete();
    append_text("\"");
    send_source();
    src_bytes.delete();
    append_text("7");
    send_source();
  endtask

  task automatic test_first_line_register();
    in_gaps    = 1'b0;
    out_stalls = 1'b1;
    // The line counter sticks at all ones.
    write_first_line('1);
    src_bytes.delete();
    append_text("a\nb");
    send_source();
    // A write in the middle of a source only takes effect for the next one.
    send_byte("q", 1'b0);
    write_first_line('0);
    send_byte(CH_LF, 1'b0);
    send_byte("5", 1'b1);
    src_bytes.delete();
    append_text("z");
    send_source();
  endtask

  task automatic test_newline_saturation();
    write_first_line(16'hFFF0 | LINE_BITS'($urandom_range(0, 15)));
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    // Enough line feeds to pin the line counter at all ones.
    repeat (NEWLINE_FLOOD) send_byte(CH_LF, 1'b0);
    send_byte("x", 1'b1);
  endtask

  task automatic test_random_sources();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) write_first_line(pick_first_line());
      in_gaps    = $urandom_range(0, 2) != 0;
      out_stalls = $urandom_range(0, 2) != 0;
      src_bytes.delete();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          append_fragment();
          if ($urandom_range(0, 2) == 0) append_byte(random_space());
        end
      end
      send_source();
      sent += src_bytes.size();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.source_char = '0;
    in_chan.is_last     = 1'b0;
    in_gaps             = 1'b0;
    out_stalls          = 1'b0;
    first_line_reg      = LINE_BITS'(1);
    restart_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_sources();
    test_first_line_register();
    test_newline_saturation();
    test_random_sources();

    wait_for_drain();
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("source_char_tokenizer_unit regression: pass");
    end else begin
      $display("source_char_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
